FILE: src/gfra_pkg.sv
// ----------------------------------------------------------------------------
// gfra_pkg
// Shared types and constants for the GB2312 font-ROM addresser: item
// structs, walker state and the glyph kind codes.
// ----------------------------------------------------------------------------
package gfra_pkg;

  localparam logic [1:0] KIND_HANZI  = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_ASCII  = 2'd2;

  localparam logic [7:0] HANZI_LO    = 8'hB0;
  localparam logic [7:0] HANZI_HI    = 8'hF7;
  localparam logic [7:0] SYMBOL_LO   = 8'hA1;
  localparam logic [7:0] SYMBOL_HI   = 8'hA3;
  localparam logic [7:0] TRAIL_LO    = 8'hA1;
  localparam logic [7:0] ASCII_LO    = 8'h20;
  localparam logic [7:0] ASCII_HI    = 8'h7E;

  localparam logic [6:0]  ROW_SPAN     = 7'd94;
  localparam logic [12:0] HANZI_OFFSET = 13'd846;
  localparam logic [17:0] ASCII_BASE   = 18'h3CF80;
  localparam logic [7:0]  WIDE_ADV     = 8'd16;
  localparam logic [7:0]  NARROW_ADV   = 8'd8;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
    logic [7:0] start_column;
    logic [2:0] start_page;
  } in_item_t;

  typedef struct packed {
    logic [17:0] font_address;
    logic [1:0]  glyph_kind;
    logic [7:0]  glyph_column;
    logic [2:0]  glyph_page;
  } out_item_t;

  typedef struct packed {
    logic [7:0] held_lead;
    logic       lead_pending;
    logic [7:0] current_column;
    logic [2:0] current_page;
    logic       string_active;
  } gfra_state_t;

endpackage

FILE: src/gfra_glyph_calc.sv
// ----------------------------------------------------------------------------
// gfra_glyph_calc
// Judges one string byte against the walker state: pairs lead and trail
// bytes, forms the font-ROM address and the next column, updates the state.
// ----------------------------------------------------------------------------
module gfra_glyph_calc (
  input  gfra_pkg::in_item_t    item,
  input  gfra_pkg::gfra_state_t state_cur,
  output gfra_pkg::gfra_state_t state_nxt,
  output logic                  res_valid,
  output gfra_pkg::out_item_t   res
);
  import gfra_pkg::*;

  always_comb begin
    gfra_state_t st;
    logic [7:0]  b;
    logic [7:0]  lead;
    logic        judge;
    logic        is_hanzi;
    logic [6:0]  row;
    logic [6:0]  col_off;
    logic [12:0] idx;
    logic [6:0]  asc;

    st        = state_cur;
    b         = item.text_byte;
    lead      = 8'd0;
    judge     = 1'b0;
    is_hanzi  = 1'b0;
    row       = 7'd0;
    col_off   = 7'd0;
    idx       = 13'd0;
    asc       = 7'd0;
    res_valid = 1'b0;
    res       = '0;

    if (item.first_byte) begin
      st.lead_pending   = 1'b0;
      st.held_lead      = 8'd0;
      st.current_column = item.start_column;
      st.current_page   = item.start_page;
      st.string_active  = 1'b1;
    end

    res.glyph_page   = st.current_page;
    res.glyph_column = st.current_column;

    if (st.string_active) begin
      if (b == 8'd0) begin
        st.string_active = 1'b0;
        st.lead_pending  = 1'b0;
        st.held_lead     = 8'd0;
      end else begin
        judge = 1'b1;
        if (st.lead_pending) begin
          lead            = st.held_lead;
          st.lead_pending = 1'b0;
          st.held_lead    = 8'd0;
          if (b >= TRAIL_LO) begin
            judge    = 1'b0;
            is_hanzi = (lead >= HANZI_LO);
            row      = is_hanzi ? 7'(lead - HANZI_LO) : 7'(lead - SYMBOL_LO);
            col_off  = 7'(b - TRAIL_LO);
            idx      = ({6'd0, row} * {6'd0, ROW_SPAN}) + {6'd0, col_off}
                       + (is_hanzi ? HANZI_OFFSET : 13'd0);
            res_valid         = 1'b1;
            res.font_address  = {idx, 5'b0};
            res.glyph_kind    = is_hanzi ? KIND_HANZI : KIND_SYMBOL;
            st.current_column = st.current_column + WIDE_ADV;
          end
        end
        if (judge) begin
          if ((b >= HANZI_LO && b <= HANZI_HI) || (b >= SYMBOL_LO && b <= SYMBOL_HI)) begin
            st.held_lead    = b;
            st.lead_pending = 1'b1;
          end else if (b >= ASCII_LO && b <= ASCII_HI) begin
            asc               = 7'(b - ASCII_LO);
            res_valid         = 1'b1;
            res.font_address  = ASCII_BASE + {7'd0, asc, 4'd0};
            res.glyph_kind    = KIND_ASCII;
            st.current_column = st.current_column + NARROW_ADV;
          end
        end
      end
    end

    state_nxt = st;
  end

endmodule

FILE: src/gb2312_font_rom_addresser_unit.sv
// ----------------------------------------------------------------------------
// gb2312_font_rom_addresser_unit
// Walks a GB2312 text stream byte by byte and gives one glyph item (font-ROM
// address, kind, column, page) per hanzi, full-width symbol or ASCII glyph.
// ----------------------------------------------------------------------------
// Takes one string byte per cycle while in_stall is low. A byte is held in
// an input register and judged once the skid entry is empty; its glyph item,
// if any, is registered into the result register, or into the skid entry
// while the output stalls. Leads, terminators and skipped bytes give no item.
// The output side has a result register plus one skid entry, so input keeps
// flowing while a result waits; in_stall rises only once the skid entry and
// the input register are both full.
module gb2312_font_rom_addresser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gfra_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gfra_pkg::out_item_t out_item
);
  import gfra_pkg::*;

  logic        inq_valid_r;
  in_item_t    inq_r;
  gfra_state_t state_r;
  gfra_state_t state_nxt;
  logic        out_valid_r;
  out_item_t   out_r;
  logic        skid_valid_r;
  out_item_t   skid_r;
  logic        res_valid;
  out_item_t   res;
  logic        in_acc;
  logic        proc;
  logic        out_free;

  gfra_glyph_calc u_calc (
    .item      (inq_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_stall  = inq_valid_r && skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign proc      = inq_valid_r && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r  <= 1'b0;
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        inq_valid_r <= 1'b1;
      end else if (proc) begin
        inq_valid_r <= 1'b0;
      end
      if (proc) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= proc && res_valid;
        end
      end else if (proc && res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inq_r <= in_item;
    end
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (proc && res_valid) begin
        out_r <= res;
      end
    end else if (proc && res_valid) begin
      skid_r <= res;
    end
  end

endmodule

FILE: dv/gfra_glyph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfra_glyph_checker
// Watches both channels of the GB2312 font-ROM addresser, decodes every
// accepted text byte the same way the block should, queues the glyph items
// it predicts and compares each accepted output item against the oldest one.
// ----------------------------------------------------------------------------
module gfra_glyph_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gfra_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gfra_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  glyphs_owed
);
  import gfra_pkg::*;

  localparam int WIDE_GLYPH_BYTES   = 32;
  localparam int NARROW_GLYPH_BYTES = 16;
  localparam int MAX_REPORT_LINES   = 40;

  gfra_state_t walk;
  out_item_t   glyph_fifo[$];

  initial mismatch_count = 0;
  initial glyphs_owed = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORT_LINES) begin
      $display("[%0t] glyph mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Advances the string walker by one byte; returns 1 when a glyph completes.
  function automatic bit decode_byte(input in_item_t it, output out_item_t g);
    logic [7:0] b;
    logic [7:0] lead;
    int         addr;
    logic [1:0] kind;
    logic [7:0] adv;
    b = it.text_byte;
    g = '0;
    if (it.first_byte) begin
      walk.held_lead      = '0;
      walk.lead_pending   = 1'b0;
      walk.current_column = it.start_column;
      walk.current_page   = it.start_page;
      walk.string_active  = 1'b1;
    end
    if (!walk.string_active) return 1'b0;
    if (b == 8'h00) begin
      walk.string_active = 1'b0;
      walk.lead_pending  = 1'b0;
      walk.held_lead     = '0;
      return 1'b0;
    end
    addr = -1;
    if (walk.lead_pending) begin
      lead = walk.held_lead;
      walk.lead_pending = 1'b0;
      walk.held_lead    = '0;
      if (b >= TRAIL_LO) begin
        if (lead >= HANZI_LO) begin
          addr = ((int'(lead) - int'(HANZI_LO)) * int'(ROW_SPAN) + (int'(b) - int'(TRAIL_LO))
                  + int'(HANZI_OFFSET)) * WIDE_GLYPH_BYTES;
          kind = KIND_HANZI;
        end else begin
          addr = ((int'(lead) - int'(SYMBOL_LO)) * int'(ROW_SPAN) + (int'(b) - int'(TRAIL_LO)))
                 * WIDE_GLYPH_BYTES;
          kind = KIND_SYMBOL;
        end
        adv = WIDE_ADV;
      end
    end
    if (addr < 0) begin
      if ((b >= HANZI_LO && b <= HANZI_HI) || (b >= SYMBOL_LO && b <= SYMBOL_HI)) begin
        walk.held_lead    = b;
        walk.lead_pending = 1'b1;
        return 1'b0;
      end
      if (b < ASCII_LO || b > ASCII_HI) return 1'b0;
      addr = (int'(b) - int'(ASCII_LO)) * NARROW_GLYPH_BYTES + int'(ASCII_BASE);
      kind = KIND_ASCII;
      adv  = NARROW_ADV;
    end
    g.font_address = addr[17:0];
    g.glyph_kind   = kind;
    g.glyph_column = walk.current_column;
    g.glyph_page   = walk.current_page;
    walk.current_column = walk.current_column + adv;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      walk = '0;
      glyph_fifo.delete();
      glyphs_owed <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_byte(in_item, want)) glyph_fifo.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (glyph_fifo.size() == 0) begin
          report_mismatch($sformatf("item %h arrived with none owed", out_item));
        end else begin
          want = glyph_fifo.pop_front();
          if (out_item.font_address !== want.font_address)
            report_mismatch($sformatf("font_address %h, want %h",
                                      out_item.font_address, want.font_address));
          if (out_item.glyph_kind !== want.glyph_kind)
            report_mismatch($sformatf("glyph_kind %0d, want %0d",
                                      out_item.glyph_kind, want.glyph_kind));
          if (out_item.glyph_column !== want.glyph_column)
            report_mismatch($sformatf("glyph_column %0d, want %0d",
                                      out_item.glyph_column, want.glyph_column));
          if (out_item.glyph_page !== want.glyph_page)
            report_mismatch($sformatf("glyph_page %0d, want %0d",
                                      out_item.glyph_page, want.glyph_page));
        end
      end
      glyphs_owed <= glyph_fifo.size();
    end
  end

endmodule

FILE: dv/tb_gb2312_font_rom_addresser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gb2312_font_rom_addresser_unit
// Feeds GB2312 text streams into the font-ROM addresser: a directed run over
// the byte classes and boundary glyphs, then random strings of hanzi, symbols
// and ASCII with broken leads and noise, under three idling mixes.
// ----------------------------------------------------------------------------
module tb_gb2312_font_rom_addresser_unit;
  import gfra_pkg::*;

  localparam int ITEMS_PER_PHASE = 617;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int mismatch_count;
  int glyphs_owed;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_fed = 0;
  int quiet_cycles = 0;
  bit string_open = 1'b0;

  gb2312_font_rom_addresser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  gfra_glyph_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .glyphs_owed    (glyphs_owed)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic feed_byte(input logic [7:0] b, input logic fb,
                           input logic [7:0] col, input logic [2:0] pg);
    in_item_t it;
    it.text_byte    = b;
    it.first_byte   = fb;
    it.start_column = fb ? col : 8'($urandom);
    it.start_page   = fb ? pg : 3'($urandom);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fb) string_open = 1'b1;
    if (string_open) bytes_fed++;
    if (b == 8'h00) string_open = 1'b0;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // One string: glyphs with the odd broken lead or stray byte, usually ending
  // in a terminator, otherwise left open for the bytes that follow.
  task automatic feed_string();
    logic [7:0] seq[$];
    int         n;
    int         r;
    logic [7:0] col;
    logic [2:0] pg;
    n = $urandom_range(24, 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        seq.push_back(8'($urandom_range(HANZI_HI, HANZI_LO)));
        seq.push_back(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (r < 55) begin
        seq.push_back(8'($urandom_range(SYMBOL_HI, SYMBOL_LO)));
        seq.push_back(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (r < 85) begin
        seq.push_back(8'($urandom_range(ASCII_HI, ASCII_LO)));
      end else if (r < 90) begin
        seq.push_back(8'($urandom_range(HANZI_HI, HANZI_LO)));
        seq.push_back(8'($urandom_range(TRAIL_LO - 1, 1)));
      end else if (r < 93) begin
        seq.push_back(8'($urandom_range(SYMBOL_HI, SYMBOL_LO)));
        seq.push_back(8'($urandom_range(TRAIL_LO - 1, 1)));
      end else begin
        seq.push_back(8'($urandom_range(255, 1)));
      end
    end
    if ($urandom_range(99) < 85) seq.push_back(8'h00);
    col = 8'($urandom);
    pg  = 3'($urandom);
    foreach (seq[k]) feed_byte(seq[k], k == 0, col, pg);
  endtask

  task automatic feed_noise();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) feed_byte(8'($urandom), $urandom_range(3) == 0, 8'($urandom), 3'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 65 : 0;
      rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 21 : 0;
      if (ph == 0) begin
        feed_byte(8'h41, 1'b0, 8'h00, 3'd0);   // no string open yet
        feed_byte(8'h20, 1'b1, 8'hF8, 3'd7);
        feed_byte(8'h7E, 1'b0, 8'h00, 3'd0);   // column wraps
        feed_byte(HANZI_LO, 1'b0, 8'h00, 3'd0);
        feed_byte(TRAIL_LO, 1'b0, 8'h00, 3'd0);
        feed_byte(HANZI_HI, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hFF, 1'b0, 8'h00, 3'd0);
        feed_byte(SYMBOL_LO, 1'b0, 8'h00, 3'd0);
        feed_byte(TRAIL_LO, 1'b0, 8'h00, 3'd0);
        feed_byte(SYMBOL_HI, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hFE, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hB5, 1'b0, 8'h00, 3'd0);   // lead dropped, ASCII judged alone
        feed_byte(8'h41, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hC0, 1'b0, 8'h00, 3'd0);   // lead dropped, then skipped
        feed_byte(8'hA0, 1'b0, 8'h00, 3'd0);
        feed_byte(HANZI_LO, 1'b0, 8'h00, 3'd0); // lead taken as trail
        feed_byte(HANZI_LO, 1'b0, 8'h00, 3'd0);
        feed_byte(8'h1F, 1'b0, 8'h00, 3'd0);
        feed_byte(8'h7F, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hA4, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hF8, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hD0, 1'b0, 8'h00, 3'd0);
        feed_byte(8'h00, 1'b0, 8'h00, 3'd0);   // end with a lead held
        feed_byte(8'h42, 1'b0, 8'h00, 3'd0);
        feed_byte(8'hE0, 1'b1, 8'h00, 3'd0);
        feed_byte(8'h30, 1'b1, 8'hFF, 3'd5);   // restart drops the lead
        feed_byte(8'h31, 1'b0, 8'h00, 3'd0);
      end
      while (bytes_fed < (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(9) == 0) feed_noise();
        else feed_string();
      end
      in_valid <= 1'b0;
      @(posedge clk);
      while (glyphs_owed != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && glyphs_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
